// ----- rtl/bdd_pkg.sv -----
// Shared types, codes and helpers of the block dictionary.
package bdd_pkg;

  localparam int unsigned TABLE_DEPTH_DEF     = 256;
  localparam int unsigned MAX_BLOCK_BYTES_DEF = 8;
  localparam logic [3:0]  BLOCK_BYTES_RST     = 4'd8;

  typedef enum logic [1:0] {
    REQ_FIND  = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_GET   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [63:0] block_data;
    logic [7:0]  entry_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  result_index;
    logic [63:0] result_block;
    logic [8:0]  entry_count;
  } resp_t;

  // Byte mask for the active block width, saturated to 1..max_bytes.
  function automatic logic [63:0] width_mask(logic [3:0] bb, int unsigned max_bytes);
    int unsigned n;
    logic [63:0] m;
    n = int'(bb);
    if (n < 1) n = 1;
    if (n > max_bytes) n = max_bytes;
    m = '0;
    for (int unsigned b = 0; b < 8; b++) begin
      if (b < n) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ----- rtl/bdd_store.sv -----
// Block storage: single-port write, single-port read, registered read data.
module bdd_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned DW    = 64,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/bdd_ctrl.sv -----
// Request sequencer: entry count, find scan, add, get and clear.
module bdd_ctrl #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned DW          = 64,
  parameter int unsigned AW          = 8,
  parameter int unsigned CW          = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  bdd_pkg::req_t   req_i,
  input  logic [63:0]     mask_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output bdd_pkg::resp_t  res_o,
  output logic            wr_en_o,
  output logic [AW-1:0]   wr_addr_o,
  output logic [DW-1:0]   wr_data_o,
  output logic            rd_en_o,
  output logic [AW-1:0]   rd_addr_o,
  input  logic [DW-1:0]   rd_data_i
);
  import bdd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_GET  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int unsigned IXW = (AW > 8) ? AW : 8;
  localparam int unsigned EXW = (CW > 9) ? CW : 9;
  localparam int unsigned GIW = (AW > 8) ? AW : 8;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] scan_idx_q, scan_idx_d;
  logic [DW-1:0] key_q, key_d;
  resp_t         res_q, res_d;

  logic [DW-1:0]  mask_dw;
  logic           full;
  logic           get_ok;
  logic           hit;
  logic [GIW-1:0] get_idx_ext;

  function automatic logic [7:0] to_idx(logic [AW-1:0] a);
    logic [IXW-1:0] e;
    e = IXW'(a);
    return e[7:0];
  endfunction

  function automatic logic [8:0] to_cnt(logic [CW-1:0] c);
    logic [EXW-1:0] e;
    e = EXW'(c);
    return e[8:0];
  endfunction

  assign mask_dw     = mask_i[DW-1:0];
  assign full        = (32'(count_q) >= TABLE_DEPTH);
  assign get_ok      = (32'(req_i.entry_index) < 32'(count_q)) &&
                       (32'(req_i.entry_index) < TABLE_DEPTH);
  assign get_idx_ext = GIW'(req_i.entry_index);
  assign hit         = ((rd_data_i & mask_dw) == key_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    key_d      = key_q;
    res_d      = res_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = count_q[AW-1:0];
    wr_data_o  = req_i.block_data[DW-1:0] & mask_dw;
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_FIN;
          unique case (req_i.req_type)
            REQ_FIND: begin
              key_d = req_i.block_data[DW-1:0] & mask_dw;
              if (count_q == '0) begin
                res_d = '{status: ST_MISS, result_index: '0, result_block: '0,
                          entry_count: to_cnt(count_q)};
              end else begin
                rd_en_o    = 1'b1;
                rd_addr_o  = '0;
                scan_idx_d = '0;
                state_d    = S_SCAN;
              end
            end
            REQ_ADD: begin
              if (full) begin
                res_d = '{status: ST_FULL, result_index: '0, result_block: '0,
                          entry_count: to_cnt(count_q)};
              end else begin
                wr_en_o = 1'b1;
                count_d = count_q + 1'b1;
                res_d   = '{status: ST_OK, result_index: to_idx(count_q[AW-1:0]),
                            result_block: '0, entry_count: to_cnt(count_q + 1'b1)};
              end
            end
            REQ_GET: begin
              if (get_ok) begin
                rd_en_o   = 1'b1;
                rd_addr_o = get_idx_ext[AW-1:0];
                state_d   = S_GET;
              end else begin
                res_d = '{status: ST_MISS, result_index: '0, result_block: '0,
                          entry_count: to_cnt(count_q)};
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
              res_d   = '{status: ST_OK, result_index: '0, result_block: '0,
                          entry_count: '0};
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // Data for scan_idx_q arrives now; fetch the next entry meanwhile.
        if (hit) begin
          res_d   = '{status: ST_OK, result_index: to_idx(scan_idx_q),
                      result_block: '0, entry_count: to_cnt(count_q)};
          state_d = S_FIN;
        end else if (32'(scan_idx_q) + 32'd1 >= 32'(count_q)) begin
          res_d   = '{status: ST_MISS, result_index: '0, result_block: '0,
                      entry_count: to_cnt(count_q)};
          state_d = S_FIN;
        end else begin
          rd_en_o    = 1'b1;
          rd_addr_o  = scan_idx_q + 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      S_GET: begin
        res_d   = '{status: ST_OK, result_index: '0,
                    result_block: 64'(rd_data_i & mask_dw),
                    entry_count: to_cnt(count_q)};
        state_d = S_FIN;
      end
      S_FIN: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    key_q      <= key_d;
    res_q      <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN);
  assign res_o       = res_q;

endmodule

// ----- rtl/block_dedup_dictionary_unit.sv -----
// Top level: block width register, sequencer, block storage and output register.
// Add, clear, refused: sequencer result register, then output register;
//   get reads memory first, find compares one stored entry per cycle from the memory port.
// One request at a time; the next is taken the cycle after the
//   previous result enters the output register.
// Reset: entry count cleared, block width set to 8 bytes; stored blocks keep
//   whatever they hold and are never read before being written, so there is no clearing pass.
module block_dedup_dictionary_unit #(
  parameter int unsigned TABLE_DEPTH     = bdd_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_BLOCK_BYTES = bdd_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bdd_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bdd_pkg::resp_t out_resp_o,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_wdata_i
);
  import bdd_pkg::*;

  localparam int unsigned DW = 8 * MAX_BLOCK_BYTES;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [3:0]  block_bytes_q;
  logic [63:0] mask;
  logic        res_valid, res_ready;
  resp_t       res;
  logic        out_valid_q;
  resp_t       out_q;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= BLOCK_BYTES_RST;
    end else if (cfg_we_i) begin
      block_bytes_q <= cfg_wdata_i;
    end
  end

  assign mask = width_mask(block_bytes_q, MAX_BLOCK_BYTES);

  bdd_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DW          (DW),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_req_i),
    .mask_i      (mask),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  bdd_store #(
    .DEPTH (TABLE_DEPTH),
    .DW    (DW),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Output register: take a new result whenever the slot is empty or draining.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_q;

endmodule

// ----- rtl/bdd_checker.sv -----
// Port-level checks of the block dictionary, bound to the top level.
module bdd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bdd_pkg::resp_t out_resp_o
);
  import bdd_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_resp_o))
    else $error("result changed while stalled");

  // One request in flight: busy right after a request is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_resp_o.status == ST_MISS |->
      out_resp_o.result_index == '0 && out_resp_o.result_block == '0)
    else $error("refused result carries data");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_resp_o.status == ST_FULL |->
      out_resp_o.result_index == '0 && out_resp_o.result_block == '0 &&
      out_resp_o.entry_count != '0)
    else $error("full result malformed");

endmodule

bind block_dedup_dictionary_unit bdd_checker u_bdd_checker (.*);
